// File: rtl/tcce_pkg.sv
// tcce_pkg: screen geometry, op and item codes, command/status structs and
// the tab-distance table for the text console cursor engine. No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int TAB_W  = $clog2(TAB_STOP + 1);

  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_BACK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SCROLL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  // Cursor moves applied by the datapath
  typedef enum logic [2:0] {
    MV_NONE = 3'd0,
    MV_NL   = 3'd1,
    MV_CR   = 3'd2,
    MV_HOME = 3'd3,
    MV_BACK = 3'd4,
    MV_ADV  = 3'd5
  } mv_t;

  // Decoded class of the item on the input ports
  typedef enum logic [2:0] {
    IT_CHAR = 3'd0,
    IT_NL   = 3'd1,
    IT_CR   = 3'd2,
    IT_TAB  = 3'd3,
    IT_BS   = 3'd4,
    IT_CLR  = 3'd5,
    IT_NONE = 3'd6
  } item_t;

  typedef struct packed {
    logic load;     // capture the item at the input transfer
    mv_t  move;
    logic emit;     // load the result register
    op_t  op;
    logic tab_dec;
  } tcce_cmd_t;

  typedef struct packed {
    item_t dec;
    logic  at_origin;
    logic  at_bottom;
    logic  at_last_col;
    logic  tab_one;
    logic  item_bs;
    logic  item_tab;
    logic  out_free;
  } tcce_stat_t;

  // Cells left to the next tab stop, per column
  typedef logic [COLUMNS-1:0][TAB_W-1:0] tab_lut_t;

  function automatic tab_lut_t build_tab_lut();
    tab_lut_t t;
    for (int i = 0; i < COLUMNS; i++) begin
      t[i] = TAB_W'(TAB_STOP - (i % TAB_STOP));
    end
    return t;
  endfunction

  localparam tab_lut_t TAB_LEFT = build_tab_lut();

endpackage

// File: rtl/tcce_ctrl.sv
// tcce_ctrl: one-hot sequencer that walks each item through its results.
// Depends on tcce_pkg; drives the datapath through tcce_cmd_t.
`timescale 1ns / 1ps

module tcce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcce_pkg::tcce_stat_t st,
  output tcce_pkg::tcce_cmd_t  cmd
);
  import tcce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WRITE  = 5'b00010,
    S_SCROLL = 5'b00100,
    S_CLEAR  = 5'b01000,
    S_CURSOR = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.move    = MV_NONE;
    cmd.op      = OP_WRITE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (st.dec)
            IT_CHAR, IT_TAB: state_nxt = S_WRITE;
            IT_NL: begin
              cmd.move  = MV_NL;
              state_nxt = st.at_bottom ? S_SCROLL : S_CURSOR;
            end
            IT_CR: begin
              cmd.move  = MV_CR;
              state_nxt = S_CURSOR;
            end
            IT_BS: begin
              if (!st.at_origin) begin
                cmd.move  = MV_BACK;
                state_nxt = S_WRITE;
              end
            end
            IT_CLR: begin
              cmd.move  = MV_HOME;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.op   = OP_WRITE;
          if (st.item_bs) begin
            state_nxt = S_CURSOR;
          end else if (st.at_last_col) begin
            cmd.move  = MV_NL;
            state_nxt = st.at_bottom ? S_SCROLL : S_CURSOR;
          end else begin
            cmd.move = MV_ADV;
            if (!st.item_tab || st.tab_one) begin
              state_nxt = S_CURSOR;
            end else begin
              cmd.tab_dec = 1'b1;
            end
          end
        end
      end
      S_SCROLL: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_SCROLL;
          state_nxt = S_CURSOR;
        end
      end
      S_CLEAR: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_CLEAR;
          state_nxt = S_CURSOR;
        end
      end
      S_CURSOR: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_CURSOR;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A wrapping write must be followed by a scroll or the cursor update
  a_wrap_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && st.out_free && st.at_last_col && !st.item_bs)
      |=> (state_r == S_SCROLL || state_r == S_CURSOR))
    else $error("wrap did not lead to scroll or cursor update");
`endif

endmodule

// File: rtl/tcce_dp.sv
// tcce_dp: cursor, attribute and item registers, tab counter and the result
// register. Depends on tcce_pkg; driven by tcce_ctrl commands.
`timescale 1ns / 1ps

module tcce_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_kind,
  input  logic [7:0]                   in_char_code,
  input  logic                         cfg_we,
  input  logic [7:0]                   cfg_wdata,
  input  tcce_pkg::tcce_cmd_t          cmd,
  output tcce_pkg::tcce_stat_t         st,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_op,
  output logic [tcce_pkg::ROW_W-1:0]   out_row,
  output logic [tcce_pkg::COL_W-1:0]   out_col,
  output logic [tcce_pkg::CELL_W-1:0]  out_cell_value,
  output logic [tcce_pkg::OFF_W-1:0]   out_cursor_offset,
  output logic                         out_last
);
  import tcce_pkg::*;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        attr_r;
  logic [7:0]        char_r;
  logic              item_bs_r, item_tab_r;
  logic [TAB_W-1:0]  tab_cnt_r;
  logic              out_valid_r;
  logic [1:0]        out_op_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [OFF_W-1:0]  out_off_r;
  logic              out_last_r;

  logic [CELL_W-1:0] blank_cell;
  logic [OFF_W-1:0]  cur_off;
  item_t             dec;

  assign blank_cell = {attr_r, CH_SPACE};
  assign cur_off    = OFF_W'(32'(row_r) * COLUMNS + 32'(col_r));

  always_comb begin
    unique case (in_kind)
      KIND_CHAR: begin
        if (in_char_code == CH_NEWLINE)     dec = IT_NL;
        else if (in_char_code == CH_RETURN) dec = IT_CR;
        else if (in_char_code == CH_TAB)    dec = IT_TAB;
        else                                dec = IT_CHAR;
      end
      KIND_BACK:  dec = IT_BS;
      KIND_CLEAR: dec = IT_CLR;
      default:    dec = IT_NONE;
    endcase
  end

  assign st.dec         = dec;
  assign st.at_origin   = (row_r == '0) && (col_r == '0);
  assign st.at_bottom   = (row_r == ROW_W'(ROWS - 1));
  assign st.at_last_col = (col_r == COL_W'(COLUMNS - 1));
  assign st.tab_one     = (tab_cnt_r == TAB_W'(1));
  assign st.item_bs     = item_bs_r;
  assign st.item_tab    = item_tab_r;
  assign st.out_free    = !out_valid_r || !out_stall;

  // Cursor moves
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    case (cmd.move)
      MV_NL: begin
        col_nxt = '0;
        if (!st.at_bottom) row_nxt = row_r + ROW_W'(1);
      end
      MV_CR:   col_nxt = '0;
      MV_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      MV_BACK: begin
        if (col_r == '0) begin
          row_nxt = row_r - ROW_W'(1);
          col_nxt = COL_W'(COLUMNS - 1);
        end else begin
          col_nxt = col_r - COL_W'(1);
        end
      end
      MV_ADV:  col_nxt = col_r + COL_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= ATTR_RESET;
      item_bs_r   <= 1'b0;
      item_tab_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) attr_r <= cfg_wdata;
      if (cmd.load) begin
        item_bs_r  <= (dec == IT_BS);
        item_tab_r <= (dec == IT_TAB);
      end
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r    <= in_char_code;
      tab_cnt_r <= TAB_LEFT[col_r];
    end else if (cmd.tab_dec) begin
      tab_cnt_r <= tab_cnt_r - TAB_W'(1);
    end
    if (cmd.emit) begin
      out_op_r   <= cmd.op;
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_cell_r <= blank_cell;
      out_off_r  <= '0;
      out_last_r <= 1'b0;
      case (cmd.op)
        OP_WRITE: begin
          if (!item_bs_r && !item_tab_r) out_cell_r <= {attr_r, char_r};
        end
        OP_SCROLL: begin
          out_row_r <= ROW_W'(ROWS - 1);
          out_col_r <= '0;
        end
        OP_CLEAR: begin
          out_row_r <= '0;
          out_col_r <= '0;
        end
        default: begin
          out_cell_r <= '0;
          out_off_r  <= cur_off;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_op            = out_op_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_cell_value    = out_cell_r;
  assign out_cursor_offset = out_off_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_last_is_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_op_r == OP_CURSOR))
    else $error("last flag on a result other than cursor update");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (32'(row_r) < ROWS && 32'(col_r) < COLUMNS))
    else $error("cursor outside the screen");

  a_offset_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_op_r == OP_CURSOR)
      |-> (out_off_r == OFF_W'(32'(out_row_r) * COLUMNS + 32'(out_col_r))))
    else $error("cursor offset does not match row and column");
`endif

endmodule

// File: rtl/text_console_cursor_engine_top.sv
// text_console_cursor_engine_top: console item in, screen commands out.
// An item with k results (k <= TAB_STOP + 2) holds off the input while they are issued,
// one result per cycle from the sequencer, fewer if the output is stalled.
// The transfer enters the first result state, which loads the result register when free.
// Items with no result (backspace at origin, unused kind) leave the sequencer idle.
// Reset (rst_n low, synchronous): cursor at row 0 column 0, attribute 0x0F, output empty.
`timescale 1ns / 1ps

module text_console_cursor_engine_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [7:0]                   in_char_code,
  // attribute register
  input  logic                         cfg_we,
  input  logic [7:0]                   cfg_wdata,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_op,
  output logic [tcce_pkg::ROW_W-1:0]   out_row,
  output logic [tcce_pkg::COL_W-1:0]   out_col,
  output logic [tcce_pkg::CELL_W-1:0]  out_cell_value,
  output logic [tcce_pkg::OFF_W-1:0]   out_cursor_offset,
  output logic                         out_last
);
  import tcce_pkg::*;

  // Sequencer issues one command per cycle; the datapath returns the cursor
  // and item status it needs to pick the next result.
  tcce_cmd_t  cmd;
  tcce_stat_t st;

  // Sequencer: takes an item only when idle, then steps through its results,
  // each one waiting until the result register is free (empty or being taken).
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: cursor, attribute, tab counter and the result register. The
  // result register decouples the two sides, so a new item is taken while
  // the final cursor update still waits for its transfer.
  tcce_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_op            (out_op),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_cell_value    (out_cell_value),
    .out_cursor_offset (out_cursor_offset),
    .out_last          (out_last)
  );

endmodule

// File: tb/sv/tb_text_console_cursor_engine_top.sv
// Self-checking bench for text_console_cursor_engine_top: directed and random console
// items, with a cursor predictor kept alongside. Depends on tcce_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_top;
  import tcce_pkg::*;

  // Kind code the block has no use for; it must be swallowed without output
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Settling time before an attribute write or the final verdict. It covers items
  // that produce nothing but may still be in flight.
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] code;
  } console_item_t;

  typedef struct {
    op_t              op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] cell_val;
    logic [OFF_W-1:0]  offset;
    logic              last;
  } screen_cmd_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [1:0]          in_kind        = '0;
  logic [7:0]          in_char_code   = '0;
  logic                cfg_we         = 1'b0;
  logic [7:0]          cfg_wdata      = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [1:0]          out_op;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    out_col;
  logic [CELL_W-1:0]   out_cell_value;
  logic [OFF_W-1:0]    out_cursor_offset;
  logic                out_last;

  text_console_cursor_engine_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_op            (out_op),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_cell_value    (out_cell_value),
    .out_cursor_offset (out_cursor_offset),
    .out_last          (out_last)
  );

  // 2 ns period
  always #1 clk = ~clk;

  // ------------------------------------------------------------------
  // Shared bench state
  // ------------------------------------------------------------------
  console_item_t pending_items[$];   // filled by the stimulus, drained by the driver
  screen_cmd_t   expected_cmds[$];   // predicted commands, oldest first
  screen_cmd_t   item_cmds[$];       // commands of the item being predicted

  int items_queued  = 0;
  int items_done    = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed    = 1'b0;

  // Predictor copy of the cursor and the attribute register
  logic [ROW_W-1:0] scr_row   = '0;
  logic [COL_W-1:0] scr_col   = '0;
  logic [7:0]       attr_byte = ATTR_RESET;

  // ------------------------------------------------------------------
  // Cursor predictor
  // ------------------------------------------------------------------
  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_byte, CH_SPACE};
  endfunction

  function automatic void emit_cmd(op_t op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                   logic [CELL_W-1:0] v, logic [OFF_W-1:0] off);
    screen_cmd_t cmd;
    cmd.op       = op;
    cmd.row      = r;
    cmd.col      = c;
    cmd.cell_val = v;
    cmd.offset   = off;
    cmd.last     = 1'b0;
    item_cmds.push_back(cmd);
  endfunction

  function automatic void emit_cursor();
    emit_cmd(OP_CURSOR, scr_row, scr_col, '0, OFF_W'(scr_row * COLUMNS + scr_col));
  endfunction

  // Down one row; at the bottom the screen scrolls and the cursor stays on the bottom row
  function automatic void line_feed();
    scr_col = '0;
    scr_row = scr_row + 1'b1;
    if (scr_row >= ROWS) begin
      emit_cmd(OP_SCROLL, ROW_W'(ROWS - 1), '0, blank_cell(), '0);
      scr_row = ROW_W'(ROWS - 1);
    end
    emit_cursor();
  endfunction

  // Cell write at the cursor; returns 1 when it wrapped onto the next line
  function automatic bit put_glyph(logic [7:0] ch);
    emit_cmd(OP_WRITE, scr_row, scr_col, {attr_byte, ch}, '0);
    scr_col = scr_col + 1'b1;
    if (scr_col >= COLUMNS) begin
      line_feed();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_console_item(logic [1:0] kind, logic [7:0] ch);
    int stop;
    bit wrapped;
    item_cmds.delete();
    case (kind)
      KIND_CHAR: begin
        if (ch == CH_NEWLINE) begin
          line_feed();
        end else if (ch == CH_RETURN) begin
          scr_col = '0;
          emit_cursor();
        end else if (ch == CH_TAB) begin
          // blanks up to the next stop, but never past the line end
          stop    = (scr_col / TAB_STOP + 1) * TAB_STOP;
          wrapped = 1'b0;
          while (scr_col < stop && !wrapped) begin
            if (scr_col + 1 >= COLUMNS) begin
              wrapped = put_glyph(CH_SPACE);
            end else begin
              emit_cmd(OP_WRITE, scr_row, scr_col, blank_cell(), '0);
              scr_col = scr_col + 1'b1;
            end
          end
          if (!wrapped) emit_cursor();
        end else if (!put_glyph(ch)) begin
          emit_cursor();
        end
      end
      KIND_BACK: begin
        // nothing at all at the origin
        if (scr_col != 0 || scr_row != 0) begin
          if (scr_col == 0) begin
            scr_row = scr_row - 1'b1;
            scr_col = COL_W'(COLUMNS - 1);
          end else begin
            scr_col = scr_col - 1'b1;
          end
          emit_cmd(OP_WRITE, scr_row, scr_col, blank_cell(), '0);
          emit_cursor();
        end
      end
      KIND_CLEAR: begin
        emit_cmd(OP_CLEAR, '0, '0, blank_cell(), '0);
        scr_row = '0;
        scr_col = '0;
        emit_cursor();
      end
      default: begin
      end
    endcase
    if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
    foreach (item_cmds[i]) expected_cmds.push_back(item_cmds[i]);
  endfunction

  // ------------------------------------------------------------------
  // Input driver: one item per transfer, random gaps, payload held while stalled
  // ------------------------------------------------------------------
  always @(posedge clk) begin : input_driver
    console_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // transfer completing at this edge: predict with the sampled payload
      if (in_valid && !in_stall) begin
        predict_console_item(in_kind, in_char_code);
        items_done++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt          = pending_items.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= nxt.kind;
          in_char_code <= nxt.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result monitor and receiver stall. The long hold-off is counted here
  // and fires once, when the stimulus arms it.
  // ------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : result_monitor
    screen_cmd_t exp_cmd;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result: op %0d row %0d col %0d", out_op, out_row, out_col);
        mismatches++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        check_field("op",            16'(exp_cmd.op),       16'(out_op));
        check_field("row",           16'(exp_cmd.row),      16'(out_row));
        check_field("col",           16'(exp_cmd.col),      16'(out_col));
        check_field("cell_value",    exp_cmd.cell_val,      out_cell_value);
        check_field("cursor_offset", 16'(exp_cmd.offset),   16'(out_cursor_offset));
        check_field("last",          16'(exp_cmd.last),     16'(out_last));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  task automatic add_item(logic [1:0] kind, logic [7:0] code);
    console_item_t it;
    it.kind = kind;
    it.code = code;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Mostly plain console traffic, with bursts that reach the bottom row,
  // wrap lines or walk the cursor back across row boundaries.
  task automatic add_random_items(int count);
    int n;
    int pick;
    int run;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        run = $urandom_range(20, 30);
        repeat (run) add_item(KIND_CHAR, CH_NEWLINE);
        n += run;
      end else if (pick < 7) begin
        run = $urandom_range(30, 90);
        repeat (run) add_item(KIND_CHAR, 8'($urandom_range(32, 126)));
        n += run;
      end else if (pick < 10) begin
        run = $urandom_range(5, 20);
        repeat (run) add_item(KIND_BACK, 8'($urandom_range(0, 255)));
        n += run;
      end else begin
        pick = $urandom_range(99);
        if (pick < 40)      add_item(KIND_CHAR, 8'($urandom_range(32, 126)));
        else if (pick < 52) add_item(KIND_CHAR, 8'($urandom_range(0, 255)));
        else if (pick < 64) add_item(KIND_CHAR, CH_NEWLINE);
        else if (pick < 71) add_item(KIND_CHAR, CH_RETURN);
        else if (pick < 83) add_item(KIND_CHAR, CH_TAB);
        else if (pick < 94) add_item(KIND_BACK, 8'($urandom_range(0, 255)));
        else if (pick < 97) add_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
        else                add_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  // Every transfer done and every command seen, then let the pipe settle
  task automatic wait_idle();
    while (items_done != items_queued || expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    attr_byte = value;
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 80;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, under the reset attribute
    add_item(KIND_BACK, 8'hFF);         // backspace at the origin: silent
    add_item(KIND_UNUSED, 8'hFF);       // unused kind: silent
    add_item(KIND_CHAR, 8'h00);
    add_item(KIND_CHAR, 8'hFF);
    add_item(KIND_CHAR, CH_RETURN);
    add_item(KIND_CHAR, CH_TAB);        // col 0 to 8
    add_item(KIND_CHAR, CH_TAB);        // a full stop's worth of blanks
    add_item(KIND_CHAR, CH_NEWLINE);
    add_item(KIND_BACK, 8'h00);         // wraps back to the end of row 0
    add_item(KIND_CHAR, CH_TAB);        // tab in the last column: wraps, stops there
    add_item(KIND_BACK, 8'h00);
    add_item(KIND_CHAR, 8'h5A);         // write in the last column wraps
    add_item(KIND_BACK, 8'h00);
    add_item(KIND_CLEAR, 8'hAA);
    // newline at the bottom row: walk down and scroll twice
    repeat (ROWS + 1) add_item(KIND_CHAR, CH_NEWLINE);
    add_item(KIND_CHAR, 8'h41);
    add_item(KIND_CLEAR, 8'h55);
    wait_idle();

    // Low attribute extreme; sender light, receiver heavy idling
    write_attr(8'h00);
    add_random_items(73);
    wait_idle();

    // High extreme; the roles swap
    send_idle_pct = 80;
    recv_idle_pct = 27;
    write_attr(8'hFF);
    add_random_items(73);
    wait_idle();

    // Random attribute, no idling, plus one long receiver hold-off so that
    // the block backs up and stalls its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_attr(8'($urandom_range(1, 254)));
    hold_armed = 1'b1;
    add_random_items(73);
    wait_idle();

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
